// ----- design/sha1_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1_pkg
// shared constants and types of the streaming sha-1 hasher
// ----------------------------------------------------------------------------
package sha1_pkg;
    localparam int BlockWords = 16;
    localparam int WordAw     = 4;
    localparam int ChainAw    = 3;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       finish;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    function automatic logic [31:0] init_word(input logic [2:0] idx);
        case (idx)
            3'd0:    init_word = H0;
            3'd1:    init_word = H1;
            3'd2:    init_word = H2;
            3'd3:    init_word = H3;
            default: init_word = H4;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] r);
        if (r < 7'd20)      round_k = K0;
        else if (r < 7'd40) round_k = K1;
        else if (r < 7'd60) round_k = K2;
        else                round_k = K3;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        if (r < 7'd20)      round_f = (b & c) | (~b & d);
        else if (r < 7'd40) round_f = b ^ c ^ d;
        else if (r < 7'd60) round_f = (b & c) | (b & d) | (c & d);
        else                round_f = b ^ c ^ d;
    endfunction
endpackage

// ----- design/sha1_if.sv -----
// ----------------------------------------------------------------------------
// sha1_in_if / sha1_out_if
// valid/ready channels of the hasher
// ----------------------------------------------------------------------------
interface sha1_in_if;
    logic                valid;
    logic                ready;
    sha1_pkg::t_in_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sha1_out_if;
    logic                valid;
    logic                ready;
    sha1_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/sha1_ram.sv -----
// ----------------------------------------------------------------------------
// sha1_ram
// generic single-write ram with one registered read port
// ----------------------------------------------------------------------------
module sha1_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/sha1_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// streaming sha-1 hasher built around a 16-word message schedule ram
// ----------------------------------------------------------------------------
// i_in carries one item: an optional message byte and a finish flag.
// bytes are packed into 32-bit words and written to a 16-entry schedule
// ram; the chaining words live in a second small ram.
// a byte item is taken while the block is idle.  the byte that completes
// 64 bytes starts a compression: it loads the chaining words, runs 80
// rounds (each reads a schedule word, then combines it and shifts the
// message or expanded word into a 16-word window) and adds back into the chaining
// ram, with i_in not ready throughout.
// a finish item appends padding and the bit length one word per cycle,
// runs one compression, or two when the length does not fit after the
// pad byte, and then offers the five digest words on o_out, index 0 first;
// each word is read from the chaining ram and then held until accepted.
// the next item is taken after the last word has been accepted.
// while o_out is stalled the word holds and nothing else moves.
// reset is synchronous, active low, and restores the initial chaining
// words through a write sweep of all five, during which no item is taken.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sha1_in_if.sink   i_in,
    sha1_out_if.source o_out
);
    import sha1_pkg::*;

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_PAD  = 4'd2;
    localparam logic [3:0] S_LDC  = 4'd3;
    localparam logic [3:0] S_RRD  = 4'd4;
    localparam logic [3:0] S_RWR  = 4'd5;
    localparam logic [3:0] S_UPR  = 4'd6;
    localparam logic [3:0] S_UPW  = 4'd7;
    localparam logic [3:0] S_ORD  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;
    localparam logic [3:0] S_LDW  = 4'd10;

    logic [3:0]  r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_len, n_len;
    logic [23:0] r_acc, n_acc;
    logic        r_fin, n_fin;
    logic        r_final, n_final;
    logic        r_tail, n_tail;
    logic        r_ovf, n_ovf;
    logic [6:0]  r_rnd, n_rnd;
    logic [2:0]  r_ci, n_ci;
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] n_a, n_b, n_c, n_d, n_e;
    logic [31:0] r_w [BlockWords];
    logic [31:0] n_w [BlockWords];
    logic [31:0] r_dout, n_dout;

    logic             w_we, c_we;
    logic [WordAw-1:0] w_waddr, w_raddr;
    logic [31:0]      w_wdata, w_rdata;
    logic [ChainAw-1:0] c_waddr, c_raddr;
    logic [31:0]      c_wdata, c_rdata;

    sha1_ram #(.Width(32), .Depth(BlockWords)) u_sched (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    sha1_ram #(.Width(32), .Depth(8)) u_chain (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    logic        acc_item;
    logic        pad_ovf;
    logic [31:0] word_now;
    logic [31:0] exp_w, rnd_w, t_val;
    logic [63:0] bits;

    assign acc_item = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.payload.digest_word = r_dout;
    assign o_out.payload.word_index  = r_ci;
    assign o_out.payload.last_word   = (r_ci == 3'd4);
    assign bits = {r_len, 3'b000};
    // pad byte lands in the last two words, length goes to an extra block
    assign pad_ovf = r_ovf || (r_fin && (r_fill[5:2] >= 4'd14));

    always_comb begin
        exp_w = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        exp_w = {exp_w[30:0], exp_w[31]};
        rnd_w = (r_rnd < 7'd16) ? w_rdata : exp_w;
        t_val = {r_a[26:0], r_a[31:27]} + round_f(r_rnd, r_b, r_c, r_d) + r_e
                + round_k(r_rnd) + rnd_w;
    end

    always_comb begin
        n_state = r_state; n_fill = r_fill; n_len = r_len; n_acc = r_acc;
        n_fin = r_fin; n_final = r_final; n_rnd = r_rnd; n_ci = r_ci;
        n_tail = r_tail; n_ovf = r_ovf;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e;
        n_dout = r_dout;
        for (int i = 0; i < BlockWords; i++) n_w[i] = r_w[i];
        w_we = 1'b0; w_waddr = r_fill[5:2]; w_wdata = 32'd0; w_raddr = r_rnd[3:0];
        c_we = 1'b0; c_waddr = r_ci; c_wdata = 32'd0; c_raddr = r_ci;
        word_now = {r_acc, PadByte};
        case (r_state)
            S_INIT: begin
                c_we = 1'b1; c_wdata = init_word(r_ci);
                n_ci = r_ci + 3'd1;
                if (r_ci == 3'd4) begin
                    n_ci = 3'd0; n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc_item) begin
                    n_fin = i_in.payload.finish;
                    if (i_in.payload.byte_valid) begin
                        n_len = r_len + 61'd1;
                        n_fill = r_fill + 6'd1;
                        case (r_fill[1:0])
                            2'd0: n_acc[23:16] = i_in.payload.data_byte;
                            2'd1: n_acc[15:8]  = i_in.payload.data_byte;
                            2'd2: n_acc[7:0]   = i_in.payload.data_byte;
                            default: begin
                                w_we = 1'b1;
                                w_wdata = {r_acc, i_in.payload.data_byte};
                            end
                        endcase
                        if (r_fill == 6'd63) begin
                            n_final = 1'b0; n_ci = 3'd0; n_state = S_LDC;
                            n_tail = i_in.payload.finish;
                        end else if (i_in.payload.finish) begin
                            n_state = S_PAD;
                        end
                    end else if (i_in.payload.finish) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                // 0x80 into the partial word, zeros, length if it fits
                w_we = 1'b1; w_waddr = r_fill[5:2];
                if (r_fin) begin
                    case (r_fill[1:0])
                        2'd0: w_wdata = {PadByte, 24'd0};
                        2'd1: w_wdata = {r_acc[23:16], PadByte, 16'd0};
                        2'd2: w_wdata = {r_acc[23:8], PadByte, 8'd0};
                        default: w_wdata = word_now;
                    endcase
                end
                if (!pad_ovf && r_fill[5:2] == 4'd14) w_wdata = bits[63:32];
                if (!pad_ovf && r_fill[5:2] == 4'd15) w_wdata = bits[31:0];
                n_fin = 1'b0;
                n_ovf = pad_ovf;
                n_fill = {r_fill[5:2] + 4'd1, 2'b00};
                if (r_fill[5:2] == 4'd15) begin
                    n_fill = 6'd0; n_ci = 3'd0; n_ovf = 1'b0;
                    n_final = !pad_ovf; n_tail = pad_ovf;
                    n_state = S_LDC;
                end
            end
            S_LDC: begin
                n_state = S_LDW;
            end
            S_LDW: begin
                case (r_ci)
                    3'd0: n_a = c_rdata;
                    3'd1: n_b = c_rdata;
                    3'd2: n_c = c_rdata;
                    3'd3: n_d = c_rdata;
                    default: n_e = c_rdata;
                endcase
                n_ci = r_ci + 3'd1;
                n_state = S_LDC;
                if (r_ci == 3'd4) begin
                    n_ci = 3'd0; n_rnd = 7'd0; n_state = S_RRD;
                end
            end
            S_RRD: begin
                n_state = S_RWR;
            end
            S_RWR: begin
                for (int i = 0; i < BlockWords - 1; i++) n_w[i] = r_w[i+1];
                n_w[BlockWords-1] = rnd_w;
                n_e = r_d; n_d = r_c; n_c = {r_b[1:0], r_b[31:2]}; n_b = r_a; n_a = t_val;
                n_rnd = r_rnd + 7'd1;
                n_state = S_RRD;
                if (r_rnd == 7'd79) begin
                    n_ci = 3'd0; n_state = S_UPR;
                end
            end
            S_UPR: begin
                n_state = S_UPW;
            end
            S_UPW: begin
                c_we = 1'b1;
                case (r_ci)
                    3'd0: c_wdata = c_rdata + r_a;
                    3'd1: c_wdata = c_rdata + r_b;
                    3'd2: c_wdata = c_rdata + r_c;
                    3'd3: c_wdata = c_rdata + r_d;
                    default: c_wdata = c_rdata + r_e;
                endcase
                n_ci = r_ci + 3'd1;
                n_state = S_UPR;
                if (r_ci == 3'd4) begin
                    n_ci = 3'd0;
                    n_fill = 6'd0;
                    c_raddr = 3'd0;
                    if (r_final) n_state = S_ORD;
                    else if (r_tail) n_state = S_PAD;
                    else n_state = S_IDLE;
                end
            end
            S_ORD: begin
                n_dout = c_rdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_out.ready) begin
                    c_we = 1'b1; c_wdata = init_word(r_ci);
                    c_raddr = r_ci + 3'd1;
                    n_ci = r_ci + 3'd1;
                    n_state = S_ORD;
                    if (r_ci == 3'd4) begin
                        n_ci = 3'd0; n_len = 61'd0; n_fill = 6'd0;
                        n_fin = 1'b0; n_final = 1'b0; n_tail = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT; r_fill <= 6'd0; r_len <= 61'd0;
            r_fin <= 1'b0; r_final <= 1'b0; r_rnd <= 7'd0; r_ci <= 3'd0;
            r_tail <= 1'b0; r_ovf <= 1'b0;
        end else begin
            r_state <= n_state; r_fill <= n_fill; r_len <= n_len;
            r_fin <= n_fin; r_final <= n_final; r_rnd <= n_rnd; r_ci <= n_ci;
            r_tail <= n_tail; r_ovf <= n_ovf;
        end
        r_acc <= n_acc; r_dout <= n_dout;
        r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d; r_e <= n_e;
        for (int i = 0; i < BlockWords; i++) r_w[i] <= n_w[i];
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready) else $error("input taken while digest pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(r_dout) && $stable(r_ci)))
        else $error("digest word changed under stall");
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_ci <= 3'd4)) else $error("digest index out of range");
    a_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RWR) |-> (r_rnd <= 7'd79)) else $error("round counter overrun");
endmodule
